### src/eatbv_pkg.sv
// ----------------------------------------------------------------------------
// eatbv_pkg
// Types, constants and arithmetic helpers shared by the Euler-to-basis blocks.
// ----------------------------------------------------------------------------
`default_nettype none
package eatbv_pkg;

    localparam int XW          = 34;      // Q2.30 datapath width with headroom
    localparam int ANGLE_W     = 18;
    localparam int OUT_W       = 16;
    localparam int ATAN_N      = 24;
    localparam int FULL_TURN   = 92160;
    localparam int QTR_TURN    = 23040;
    localparam int DEG_TO_RAD  = 292818;  // round(pi * 2^32 / 46080)
    localparam int GAIN_INV    = 652032874;
    localparam int Q14_ONE     = 16384;

    typedef logic signed [XW-1:0] q30_t;

    // One angle in flight through the rotator
    typedef struct packed {
        q30_t       x;
        q30_t       y;
        q30_t       z;
        logic [1:0] quad;
    } lane_t;

    // Pitch, yaw, roll lanes (index 0, 1, 2)
    typedef lane_t [2:0] trio_t;

    // round(atan(2^-i) * 2^30)
    function automatic q30_t atan_q30(input int idx);
        q30_t v;
        case (idx)
            0:  v = XW'(843314857);
            1:  v = XW'(497837829);
            2:  v = XW'(263043837);
            3:  v = XW'(133525159);
            4:  v = XW'(67021687);
            5:  v = XW'(33543516);
            6:  v = XW'(16775851);
            7:  v = XW'(8388437);
            8:  v = XW'(4194283);
            9:  v = XW'(2097149);
            10: v = XW'(1048576);
            11: v = XW'(524288);
            12: v = XW'(262144);
            13: v = XW'(131072);
            14: v = XW'(65536);
            15: v = XW'(32768);
            16: v = XW'(16384);
            17: v = XW'(8192);
            18: v = XW'(4096);
            19: v = XW'(2048);
            20: v = XW'(1024);
            21: v = XW'(512);
            22: v = XW'(256);
            default: v = XW'(128);
        endcase
        return v;
    endfunction

    // Q2.30 product, rounded half up back to Q2.30
    function automatic q30_t mulq(input q30_t a, input q30_t b);
        logic signed [2*XW-1:0] p;
        logic signed [2*XW-1:0] r;
        p = a * b;
        r = (p + (2*XW)'(64'sd536870912)) >>> 30;
        return r[XW-1:0];
    endfunction

    // Q2.30 to Q1.14 with rounding and saturation to unit magnitude
    function automatic logic signed [OUT_W-1:0] to_q14(input logic signed [XW+1:0] v);
        logic signed [XW+1:0] r;
        r = (v + (XW+2)'(32768)) >>> 16;
        if (r > (XW+2)'(Q14_ONE)) begin
            r = (XW+2)'(Q14_ONE);
        end else if (r < -(XW+2)'(Q14_ONE)) begin
            r = -(XW+2)'(Q14_ONE);
        end
        return r[OUT_W-1:0];
    endfunction

endpackage
`default_nettype wire

### src/eatbv_prep.sv
// ----------------------------------------------------------------------------
// eatbv_prep
// Wraps three degree angles into one turn, splits off the quadrant and
// converts the remainder to Q2.30 radians (two stages).
// ----------------------------------------------------------------------------
`default_nettype none
module eatbv_prep (
    input  wire logic                                   aclk,
    input  wire logic                                   aresetn,
    input  wire logic                                   en,
    input  wire logic                                   valid_in,
    input  wire logic signed [eatbv_pkg::ANGLE_W-1:0]   ang_in [3],
    output      logic                                   valid_out,
    output      eatbv_pkg::trio_t                       trio_out
);
    import eatbv_pkg::*;

    logic        v1_reg;
    logic [14:0] rem_reg  [3];
    logic [1:0]  quad_reg [3];
    logic        v2_reg;
    trio_t       trio_reg;

    logic [14:0] rem_next  [3];
    logic [1:0]  quad_next [3];

    // Wrap into [0, 360) degrees and split into quadrant and remainder
    always_comb begin
        logic signed [19:0] a;
        for (int k = 0; k < 3; k++) begin
            a = 20'(ang_in[k]);
            if (a < -20'sd92160) begin
                a = a + 20'sd184320;
            end else if (a < 20'sd0) begin
                a = a + 20'sd92160;
            end else if (a >= 20'sd92160) begin
                a = a - 20'sd92160;
            end
            if (a >= 20'sd69120) begin
                quad_next[k] = 2'd3;
                a = a - 20'sd69120;
            end else if (a >= 20'sd46080) begin
                quad_next[k] = 2'd2;
                a = a - 20'sd46080;
            end else if (a >= 20'sd23040) begin
                quad_next[k] = 2'd1;
                a = a - 20'sd23040;
            end else begin
                quad_next[k] = 2'd0;
            end
            rem_next[k] = a[14:0];
        end
    end

    // Register the split, then scale to radians
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end else if (en) begin
            v1_reg <= valid_in;
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge aclk) begin
        logic [33:0] prod;
        if (en) begin
            for (int k = 0; k < 3; k++) begin
                rem_reg[k]  <= rem_next[k];
                quad_reg[k] <= quad_next[k];
                prod = 34'(rem_reg[k]) * 34'(DEG_TO_RAD) + 34'd2;
                trio_reg[k].z    <= XW'(prod >> 2);
                trio_reg[k].x    <= XW'(GAIN_INV);
                trio_reg[k].y    <= '0;
                trio_reg[k].quad <= quad_reg[k];
            end
        end
    end

    assign valid_out = v2_reg;
    assign trio_out  = trio_reg;

endmodule
`default_nettype wire

### src/eatbv_cell.sv
// ----------------------------------------------------------------------------
// eatbv_cell
// One CORDIC rotation step for the three angle lanes, registered.
// ----------------------------------------------------------------------------
`default_nettype none
module eatbv_cell #(
    parameter int IDX = 0
) (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              en,
    input  wire logic              valid_in,
    input  wire eatbv_pkg::trio_t  trio_in,
    output      logic              valid_out,
    output      eatbv_pkg::trio_t  trio_out
);
    import eatbv_pkg::*;

    logic  valid_reg;
    trio_t trio_reg;
    trio_t trio_next;

    // Rotate toward zero residual angle
    always_comb begin
        q30_t dx;
        q30_t dy;
        for (int k = 0; k < 3; k++) begin
            dx = trio_in[k].y >>> IDX;
            dy = trio_in[k].x >>> IDX;
            trio_next[k].quad = trio_in[k].quad;
            if (trio_in[k].z >= 0) begin
                trio_next[k].x = trio_in[k].x - dx;
                trio_next[k].y = trio_in[k].y + dy;
                trio_next[k].z = trio_in[k].z - atan_q30(IDX);
            end else begin
                trio_next[k].x = trio_in[k].x + dx;
                trio_next[k].y = trio_in[k].y - dy;
                trio_next[k].z = trio_in[k].z + atan_q30(IDX);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (en) begin
            valid_reg <= valid_in;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            trio_reg <= trio_next;
        end
    end

    assign valid_out = valid_reg;
    assign trio_out  = trio_reg;

endmodule
`default_nettype wire

### src/eatbv_basis.sv
// ----------------------------------------------------------------------------
// eatbv_basis
// Applies the residual-angle correction and quadrant mapping, then forms
// the forward, right and up vectors and holds them in the output register.
// ----------------------------------------------------------------------------
`default_nettype none
module eatbv_basis (
    input  wire logic                                 aclk,
    input  wire logic                                 aresetn,
    input  wire logic                                 en,
    input  wire logic                                 valid_in,
    input  wire eatbv_pkg::trio_t                     trio_in,
    output      logic                                 valid_out,
    output      logic signed [eatbv_pkg::OUT_W-1:0]   vec_out [9]
);
    import eatbv_pkg::*;

    // Correction stage 1: residual products
    logic       c1_v_reg;
    q30_t       c1_x_reg [3];
    q30_t       c1_y_reg [3];
    q30_t       c1_zy_reg [3];
    q30_t       c1_zx_reg [3];
    logic [1:0] c1_q_reg [3];
    // Correction stage 2: sine and cosine per lane
    logic       c2_v_reg;
    q30_t       s_reg [3];
    q30_t       c_reg [3];
    // First product stage
    logic       m1_v_reg;
    q30_t       sp_reg, sr_reg, cr_reg;
    q30_t       spcy_reg, spsy_reg, cpcy_reg, cpsy_reg, crsy_reg;
    q30_t       crcy_reg, srsy_reg, srcy_reg, srcp_reg, crcp_reg;
    // Second product stage
    logic       m2_v_reg;
    q30_t       m2_sp_reg, m2_cpcy_reg, m2_cpsy_reg, m2_crsy_reg, m2_crcy_reg;
    q30_t       m2_srsy_reg, m2_srcy_reg, m2_srcp_reg, m2_crcp_reg;
    q30_t       srspcy_reg, srspsy_reg, crspcy_reg, crspsy_reg;
    // Output register
    logic                     o_v_reg;
    logic signed [OUT_W-1:0]  o_reg [9];

    // Advance the valid bits
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            c1_v_reg <= 1'b0;
            c2_v_reg <= 1'b0;
            m1_v_reg <= 1'b0;
            m2_v_reg <= 1'b0;
            o_v_reg  <= 1'b0;
        end else if (en) begin
            c1_v_reg <= valid_in;
            c2_v_reg <= c1_v_reg;
            m1_v_reg <= c2_v_reg;
            m2_v_reg <= m1_v_reg;
            o_v_reg  <= m2_v_reg;
        end
    end

    always_ff @(posedge aclk) begin
        q30_t cc;
        q30_t ss;
        if (en) begin
            // First-order correction by the residual angle
            for (int k = 0; k < 3; k++) begin
                c1_x_reg[k]  <= trio_in[k].x;
                c1_y_reg[k]  <= trio_in[k].y;
                c1_zy_reg[k] <= mulq(trio_in[k].z, trio_in[k].y);
                c1_zx_reg[k] <= mulq(trio_in[k].z, trio_in[k].x);
                c1_q_reg[k]  <= trio_in[k].quad;
            end
            // Finish sine and cosine, map the quadrant
            for (int k = 0; k < 3; k++) begin
                cc = c1_x_reg[k] - c1_zy_reg[k];
                ss = c1_y_reg[k] + c1_zx_reg[k];
                case (c1_q_reg[k])
                    2'd0:    begin s_reg[k] <= ss;  c_reg[k] <= cc;  end
                    2'd1:    begin s_reg[k] <= cc;  c_reg[k] <= -ss; end
                    2'd2:    begin s_reg[k] <= -ss; c_reg[k] <= -cc; end
                    default: begin s_reg[k] <= -cc; c_reg[k] <= ss;  end
                endcase
            end
            // Pairwise products (lane 0 pitch, 1 yaw, 2 roll)
            sp_reg   <= s_reg[0];
            sr_reg   <= s_reg[2];
            cr_reg   <= c_reg[2];
            spcy_reg <= mulq(s_reg[0], c_reg[1]);
            spsy_reg <= mulq(s_reg[0], s_reg[1]);
            cpcy_reg <= mulq(c_reg[0], c_reg[1]);
            cpsy_reg <= mulq(c_reg[0], s_reg[1]);
            crsy_reg <= mulq(c_reg[2], s_reg[1]);
            crcy_reg <= mulq(c_reg[2], c_reg[1]);
            srsy_reg <= mulq(s_reg[2], s_reg[1]);
            srcy_reg <= mulq(s_reg[2], c_reg[1]);
            srcp_reg <= mulq(s_reg[2], c_reg[0]);
            crcp_reg <= mulq(c_reg[2], c_reg[0]);
            // Triple products
            srspcy_reg  <= mulq(sr_reg, spcy_reg);
            srspsy_reg  <= mulq(sr_reg, spsy_reg);
            crspcy_reg  <= mulq(cr_reg, spcy_reg);
            crspsy_reg  <= mulq(cr_reg, spsy_reg);
            m2_sp_reg   <= sp_reg;
            m2_cpcy_reg <= cpcy_reg;
            m2_cpsy_reg <= cpsy_reg;
            m2_crsy_reg <= crsy_reg;
            m2_crcy_reg <= crcy_reg;
            m2_srsy_reg <= srsy_reg;
            m2_srcy_reg <= srcy_reg;
            m2_srcp_reg <= srcp_reg;
            m2_crcp_reg <= crcp_reg;
            // Combine and round to Q1.14
            o_reg[0] <= to_q14((XW+2)'(m2_cpcy_reg));
            o_reg[1] <= to_q14((XW+2)'(m2_cpsy_reg));
            o_reg[2] <= to_q14(-(XW+2)'(m2_sp_reg));
            o_reg[3] <= to_q14((XW+2)'(m2_crsy_reg) - (XW+2)'(srspcy_reg));
            o_reg[4] <= to_q14(-(XW+2)'(srspsy_reg) - (XW+2)'(m2_crcy_reg));
            o_reg[5] <= to_q14(-(XW+2)'(m2_srcp_reg));
            o_reg[6] <= to_q14((XW+2)'(crspcy_reg) + (XW+2)'(m2_srsy_reg));
            o_reg[7] <= to_q14((XW+2)'(crspsy_reg) - (XW+2)'(m2_srcy_reg));
            o_reg[8] <= to_q14((XW+2)'(m2_crcp_reg));
        end
    end

    assign valid_out = o_v_reg;
    assign vec_out   = o_reg;

endmodule
`default_nettype wire

### src/euler_angles_to_basis_vectors.sv
// ----------------------------------------------------------------------------
// euler_angles_to_basis_vectors
// Converts pitch, yaw and roll in degrees to forward, right and up vectors.
// ----------------------------------------------------------------------------
// Accepts one orientation per clock while the output is not stalled and
// returns one set of nine Q1.14 components per orientation, in order.
// TRIG_ITERATIONS sets the number of CORDIC cells in the rotator chain
// (values above 24 act as 24). Angle wrapping and radian scaling come
// first, then the rotator chain, then correction, products and output
// rounding. The whole pipeline holds while a result waits at the output,
// so s_ready follows m_ready when the output register is full.
`default_nettype none
module euler_angles_to_basis_vectors #(
    parameter int TRIG_ITERATIONS = 16
) (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                s_valid,
    output      logic                s_ready,
    input  wire logic signed [17:0]  s_pitch_deg,
    input  wire logic signed [17:0]  s_yaw_deg,
    input  wire logic signed [17:0]  s_roll_deg,
    output      logic                m_valid,
    input  wire logic                m_ready,
    output      logic signed [15:0]  m_fwd_x,
    output      logic signed [15:0]  m_fwd_y,
    output      logic signed [15:0]  m_fwd_z,
    output      logic signed [15:0]  m_rgt_x,
    output      logic signed [15:0]  m_rgt_y,
    output      logic signed [15:0]  m_rgt_z,
    output      logic signed [15:0]  m_upv_x,
    output      logic signed [15:0]  m_upv_y,
    output      logic signed [15:0]  m_upv_z
);
    import eatbv_pkg::*;

    localparam int NITER = (TRIG_ITERATIONS > ATAN_N) ? ATAN_N : TRIG_ITERATIONS;

    logic                     adv;
    logic signed [ANGLE_W-1:0] ang [3];
    logic                     chain_v [NITER+1];
    trio_t                    chain_d [NITER+1];
    logic signed [OUT_W-1:0]  vec [9];

    // Advance everything unless a result is stuck at the output
    assign adv     = !m_valid || m_ready;
    assign s_ready = adv;

    assign ang[0] = s_pitch_deg;
    assign ang[1] = s_yaw_deg;
    assign ang[2] = s_roll_deg;

    eatbv_prep u_prep (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (adv),
        .valid_in  (s_valid),
        .ang_in    (ang),
        .valid_out (chain_v[0]),
        .trio_out  (chain_d[0])
    );

    // Rotator chain
    for (genvar i = 0; i < NITER; i++) begin : g_cell
        eatbv_cell #(.IDX(i)) u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .en        (adv),
            .valid_in  (chain_v[i]),
            .trio_in   (chain_d[i]),
            .valid_out (chain_v[i+1]),
            .trio_out  (chain_d[i+1])
        );
    end

    eatbv_basis u_basis (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (adv),
        .valid_in  (chain_v[NITER]),
        .trio_in   (chain_d[NITER]),
        .valid_out (m_valid),
        .vec_out   (vec)
    );

    assign m_fwd_x = vec[0];
    assign m_fwd_y = vec[1];
    assign m_fwd_z = vec[2];
    assign m_rgt_x = vec[3];
    assign m_rgt_y = vec[4];
    assign m_rgt_z = vec[5];
    assign m_upv_x = vec[6];
    assign m_upv_y = vec[7];
    assign m_upv_z = vec[8];

endmodule
`default_nettype wire

### src/eatbv_checker.sv
// ----------------------------------------------------------------------------
// eatbv_checker
// Port-level checks for the Euler-to-basis block, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none
module eatbv_checker (
    input wire logic               aclk,
    input wire logic               aresetn,
    input wire logic               s_ready,
    input wire logic               m_valid,
    input wire logic               m_ready,
    input wire logic signed [15:0] m_fwd_x,
    input wire logic signed [15:0] m_fwd_z,
    input wire logic signed [15:0] m_upv_z
);

    // Hold a stalled transaction
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_fwd_x) && $stable(m_upv_z))
        else $error("stalled result changed");

    // Accept input whenever the output side can move
    a_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_valid || m_ready |-> s_ready)
        else $error("input stalled while output free");

    // Keep the forward z and up z components within unit magnitude
    a_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_fwd_z <= 16'sd16384 && m_fwd_z >= -16'sd16384
                 && m_upv_z <= 16'sd16384 && m_upv_z >= -16'sd16384)
        else $error("component out of range");

endmodule

bind euler_angles_to_basis_vectors eatbv_checker u_eatbv_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_ready (s_ready),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_fwd_x (m_fwd_x),
    .m_fwd_z (m_fwd_z),
    .m_upv_z (m_upv_z)
);
`default_nettype wire
